[src/assert_macros.svh]
// Assertion macros for the stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define DUFFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define DUFFE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/duffe_pkg.sv]
// Types, constants, sine table builder and microcode for the Duffing Euler stepper.
package duffe_pkg;

  localparam int DATA_W           = 32;
  localparam int FRAC_BITS        = 24;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int STEP_W           = 31;
  localparam int ACC_W            = 36;
  localparam int PROD_W           = 2 * DATA_W;

  localparam int SIN_AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SIN_W  = FRAC_BITS + 1;
  localparam int IDX_PW = 30 + SIN_AW;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUBIC      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_AMP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd5;

  localparam logic [STEP_W-1:0] RST_STEP_SIZE  = 31'd167772;
  localparam logic [DATA_W-1:0] RST_DAMPING    = 32'd1677722;
  localparam logic [DATA_W-1:0] RST_CUBIC      = 32'd8388608;
  localparam logic [DATA_W-1:0] RST_DRIVE_AMP  = 32'd3355443;
  localparam logic [DATA_W-1:0] RST_PHASE_STEP = 32'd683565;
  localparam logic [DATA_W-1:0] RST_OFFSET     = 32'd0;

  localparam logic MODE_LOAD = 1'b0;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] load_position;
    logic signed [DATA_W-1:0] load_velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
  } out_item_t;

  // Microcode step addresses.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_S0   = 4'd0;
  localparam logic [UPC_W-1:0] UPC_S1   = 4'd1;
  localparam logic [UPC_W-1:0] UPC_S2   = 4'd2;
  localparam logic [UPC_W-1:0] UPC_S3   = 4'd3;
  localparam logic [UPC_W-1:0] UPC_S4   = 4'd4;
  localparam logic [UPC_W-1:0] UPC_S5   = 4'd5;
  localparam logic [UPC_W-1:0] UPC_S6   = 4'd6;
  localparam logic [UPC_W-1:0] UPC_S7   = 4'd7;
  localparam logic [UPC_W-1:0] UPC_LOAD = 4'd8;

  // Multiplier operand A
  localparam logic [2:0] MA_P     = 3'd0;
  localparam logic [2:0] MA_T1    = 3'd1;
  localparam logic [2:0] MA_DRIVE = 3'd2;
  localparam logic [2:0] MA_DAMP  = 3'd3;
  localparam logic [2:0] MA_CUBIC = 3'd4;
  localparam logic [2:0] MA_H     = 3'd5;
  // Multiplier operand B
  localparam logic [1:0] MB_P    = 2'd0;
  localparam logic [1:0] MB_V    = 2'd1;
  localparam logic [1:0] MB_SINE = 2'd2;
  localparam logic [1:0] MB_T1   = 2'd3;
  // Accumulator operation
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_INIT = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;
  // Temporary register source
  localparam logic [1:0] T1_HOLD = 2'd0;
  localparam logic [1:0] T1_Q    = 2'd1;
  localparam logic [1:0] T1_SUM  = 2'd2;
  // Finish action
  localparam logic [1:0] FIN_NONE = 2'd0;
  localparam logic [1:0] FIN_STEP = 2'd1;
  localparam logic [1:0] FIN_LOAD = 2'd2;
  // Sequencing
  localparam logic [1:0] J_NEXT = 2'd0;
  localparam logic [1:0] J_LOAD = 2'd1;
  localparam logic [1:0] J_END  = 2'd2;

  typedef struct packed {
    logic [2:0]       ma;
    logic [1:0]       mb;
    logic [1:0]       acc_op;
    logic [1:0]       t1_op;
    logic             pn_wr;
    logic [1:0]       fin;
    logic [1:0]       jmp;
    logic [UPC_W-1:0] target;
  } ucode_t;

  typedef logic [SIN_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // Control store. Words S0 to S6 each issue one product; words S1 to S7 consume
  // the one issued by the word before it.
  function automatic ucode_t ucode(input logic [UPC_W-1:0] addr);
    ucode_t w;
    w = '0;
    unique case (addr)
      UPC_S0: begin
        w.ma = MA_P;     w.mb = MB_P;    w.acc_op = ACC_INIT;
        w.jmp = J_LOAD;  w.target = UPC_LOAD;
      end
      UPC_S1: begin
        w.ma = MA_DRIVE; w.mb = MB_SINE; w.t1_op = T1_Q;
      end
      UPC_S2: begin
        w.ma = MA_T1;    w.mb = MB_P;    w.acc_op = ACC_ADD;
      end
      UPC_S3: begin
        w.ma = MA_DAMP;  w.mb = MB_V;    w.t1_op = T1_Q;
      end
      UPC_S4: begin
        w.ma = MA_CUBIC; w.mb = MB_T1;   w.acc_op = ACC_SUB;
      end
      UPC_S5: begin
        w.ma = MA_H;     w.mb = MB_V;    w.acc_op = ACC_SUB; w.t1_op = T1_SUM;
      end
      UPC_S6: begin
        w.ma = MA_H;     w.mb = MB_T1;   w.pn_wr = 1'b1;
      end
      UPC_S7: begin
        w.fin = FIN_STEP; w.jmp = J_END;
      end
      UPC_LOAD: begin
        w.fin = FIN_LOAD; w.jmp = J_END;
      end
      default: begin
        w.jmp = J_END;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (x < 64'shFFFF_FFFF_8000_0000) begin
      return 32'sh8000_0000;
    end
    return x[DATA_W-1:0];
  endfunction

  // Quarter-wave sine table, built at elaboration: Q30 Horner series of
  // sin(x), then rounded to FRAC_BITS fraction bits.
  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] pih;
    logic [63:0] half;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] one;
    one  = 64'd1 << 30;
    pih  = (64'h1921_FB54_442D_1847 + (64'd1 << 29)) >> 30;
    half = (64'd1 << (30 - FRAC_BITS)) >> 1;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x  = (64'(k) * pih + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      t  = one;
      t  = one - (((x2 * t) >> 30) / 64'd210);
      t  = one - (((x2 * t) >> 30) / 64'd156);
      t  = one - (((x2 * t) >> 30) / 64'd110);
      t  = one - (((x2 * t) >> 30) / 64'd72);
      t  = one - (((x2 * t) >> 30) / 64'd42);
      t  = one - (((x2 * t) >> 30) / 64'd20);
      t  = one - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      if (s > one) begin
        s = one;
      end
      rom[k] = SIN_W'((s + half) >> (30 - FRAC_BITS));
    end
    return rom;
  endfunction

endpackage

[src/duffing_oscillator_euler_step_top.sv]
// Forced Duffing oscillator stepper: microcoded forward Euler over one shared multiplier.
//
// Each input transfer is either a load (mode 0: set position and velocity, reset the
// forcing phase to one phase step) or an Euler step (mode 1: advance position,
// velocity and phase once). Every transfer yields exactly one result holding the
// position and velocity after it, saturated Q8.24. A step runs words S0 to S7 and a
// load runs S0 and LOAD. The next item is accepted on the same edge that finishes the
// current one, so steps run back to back while the result register is free. The step
// program is set by the chain p*p -> p^3 -> cubic term -> h*acc through the single
// 32x32 multiplier, whose product is registered before use. If the result register
// still holds an untaken result, the finishing step waits there and input stays
// stalled. The forcing sine comes from a 1025-entry quarter-wave ROM with a registered
// read that tracks the phase continuously. Configuration registers are always ready
// and must be written only while no item is in flight.
`include "assert_macros.svh"

module duffing_oscillator_euler_step_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  duffe_pkg::in_item_t                  in_data,
  // results
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output duffe_pkg::out_item_t                 out_data,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [duffe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [duffe_pkg::DATA_W-1:0]         cfg_data
);

  localparam duffe_pkg::sine_rom_t SineRom = duffe_pkg::build_sine();

  // Configuration registers
  logic [duffe_pkg::STEP_W-1:0]        step_size_r;
  logic signed [duffe_pkg::DATA_W-1:0] damping_r;
  logic signed [duffe_pkg::DATA_W-1:0] cubic_r;
  logic signed [duffe_pkg::DATA_W-1:0] drive_amp_r;
  logic [duffe_pkg::DATA_W-1:0]        phase_step_r;
  logic signed [duffe_pkg::DATA_W-1:0] offset_r;

  // Oscillator state
  logic signed [duffe_pkg::DATA_W-1:0] pos_r;
  logic signed [duffe_pkg::DATA_W-1:0] vel_r;
  logic [duffe_pkg::DATA_W-1:0]        phase_acc_r;

  // Sequencer
  logic                                busy_r;
  logic [duffe_pkg::UPC_W-1:0]         upc_r;
  duffe_pkg::in_item_t                 in_r;
  duffe_pkg::ucode_t                   uw;
  logic                                fin_req;
  logic                                hold;
  logic                                adv;
  logic                                end_fire;
  logic                                fin_step_fire;
  logic                                fin_load_fire;
  logic                                in_fire;

  // Datapath
  logic signed [duffe_pkg::DATA_W-1:0] mul_a;
  logic signed [duffe_pkg::DATA_W-1:0] mul_b;
  logic signed [duffe_pkg::PROD_W-1:0] prod_r;
  logic signed [duffe_pkg::DATA_W-1:0] q;
  logic signed [duffe_pkg::ACC_W-1:0]  acc_r;
  logic signed [duffe_pkg::ACC_W-1:0]  acc_sum;
  logic signed [duffe_pkg::DATA_W-1:0] t1_r;
  logic signed [duffe_pkg::DATA_W-1:0] pn_r;
  logic signed [duffe_pkg::DATA_W-1:0] pn_nxt;
  logic signed [duffe_pkg::DATA_W-1:0] vn_nxt;

  // Sine lookup
  logic [duffe_pkg::DATA_W-1:0]        phase_arg;
  logic [duffe_pkg::IDX_PW-1:0]        idx_prod;
  logic [duffe_pkg::SIN_AW-1:0]        idx_raw;
  logic [duffe_pkg::SIN_AW-1:0]        sine_addr;
  logic [duffe_pkg::SIN_W-1:0]         sine_q_r;
  logic                                sine_neg_r;
  logic signed [duffe_pkg::DATA_W-1:0] sine_mag;
  logic signed [duffe_pkg::DATA_W-1:0] sine_val;

  // Output register
  logic                                out_valid_r;
  logic                                out_valid_nxt;
  duffe_pkg::out_item_t                out_data_r;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, out-of-range indexes drop silently.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r  <= duffe_pkg::RST_STEP_SIZE;
      damping_r    <= duffe_pkg::RST_DAMPING;
      cubic_r      <= duffe_pkg::RST_CUBIC;
      drive_amp_r  <= duffe_pkg::RST_DRIVE_AMP;
      phase_step_r <= duffe_pkg::RST_PHASE_STEP;
      offset_r     <= duffe_pkg::RST_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        duffe_pkg::REG_STEP_SIZE:  step_size_r  <= cfg_data[duffe_pkg::STEP_W-1:0];
        duffe_pkg::REG_DAMPING:    damping_r    <= cfg_data;
        duffe_pkg::REG_CUBIC:      cubic_r      <= cfg_data;
        duffe_pkg::REG_DRIVE_AMP:  drive_amp_r  <= cfg_data;
        duffe_pkg::REG_PHASE_STEP: phase_step_r <= cfg_data;
        duffe_pkg::REG_OFFSET:     offset_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sine ROM: quadrant from the top two argument bits, entry from the rest
  // scaled by the table depth, mirrored in odd quadrants, negated in the
  // second half turn. Read every cycle; the phase is steady during a step.
  // ---------------------------------------------------------------------------
  assign phase_arg = phase_acc_r + phase_step_r;
  assign idx_prod  = duffe_pkg::IDX_PW'(phase_arg[29:0])
                   * duffe_pkg::IDX_PW'(duffe_pkg::SINE_TABLE_DEPTH);
  assign idx_raw   = idx_prod[duffe_pkg::IDX_PW-1:30];
  assign sine_addr = phase_arg[30]
                   ? duffe_pkg::SIN_AW'(duffe_pkg::SINE_TABLE_DEPTH) - idx_raw
                   : idx_raw;

  always_ff @(posedge clk) begin
    sine_q_r   <= SineRom[sine_addr];
    sine_neg_r <= phase_arg[31];
  end

  assign sine_mag = duffe_pkg::DATA_W'(sine_q_r);
  assign sine_val = sine_neg_r ? -sine_mag : sine_mag;

  // ---------------------------------------------------------------------------
  // Control word decode and handshake
  // ---------------------------------------------------------------------------
  assign uw       = duffe_pkg::ucode(upc_r);
  assign fin_req  = uw.fin != duffe_pkg::FIN_NONE;
  // Hold the finishing word while the result register is still occupied.
  assign hold     = fin_req && out_valid_r && out_stall;
  assign adv      = busy_r && !hold;
  assign end_fire = adv && (uw.jmp == duffe_pkg::J_END);
  assign fin_step_fire = adv && (uw.fin == duffe_pkg::FIN_STEP);
  assign fin_load_fire = adv && (uw.fin == duffe_pkg::FIN_LOAD);

  // Take a new item on the edge that retires the current one.
  assign in_stall = busy_r && !end_fire;
  assign in_fire  = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Shared multiplier operands
  // ---------------------------------------------------------------------------
  always_comb begin
    case (uw.ma)
      duffe_pkg::MA_P:     mul_a = pos_r;
      duffe_pkg::MA_T1:    mul_a = t1_r;
      duffe_pkg::MA_DRIVE: mul_a = drive_amp_r;
      duffe_pkg::MA_DAMP:  mul_a = damping_r;
      duffe_pkg::MA_CUBIC: mul_a = cubic_r;
      duffe_pkg::MA_H:     mul_a = {1'b0, step_size_r};
      default:             mul_a = pos_r;
    endcase
  end

  always_comb begin
    case (uw.mb)
      duffe_pkg::MB_P:    mul_b = pos_r;
      duffe_pkg::MB_V:    mul_b = vel_r;
      duffe_pkg::MB_SINE: mul_b = sine_val;
      duffe_pkg::MB_T1:   mul_b = t1_r;
      default:            mul_b = pos_r;
    endcase
  end

  // Product scaled back to the fixed-point grid: the arithmetic shift floors.
  assign q = duffe_pkg::sat32(prod_r >>> duffe_pkg::FRAC_BITS);

  assign acc_sum = (uw.acc_op == duffe_pkg::ACC_SUB)
                 ? acc_r - duffe_pkg::ACC_W'(q)
                 : acc_r + duffe_pkg::ACC_W'(q);

  assign pn_nxt = duffe_pkg::sat32(duffe_pkg::PROD_W'(pos_r) + duffe_pkg::PROD_W'(q));
  assign vn_nxt = duffe_pkg::sat32(duffe_pkg::PROD_W'(vel_r) + duffe_pkg::PROD_W'(q));

  // ---------------------------------------------------------------------------
  // Datapath registers: advance with the sequencer; in_r captures each accepted item.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (adv) begin
      prod_r <= mul_a * mul_b;
      case (uw.acc_op) inside
        duffe_pkg::ACC_INIT:
          acc_r <= duffe_pkg::ACC_W'(offset_r) - duffe_pkg::ACC_W'(pos_r);
        duffe_pkg::ACC_ADD, duffe_pkg::ACC_SUB:
          acc_r <= acc_sum;
        default: ;
      endcase
      case (uw.t1_op)
        duffe_pkg::T1_Q:   t1_r <= q;
        duffe_pkg::T1_SUM: t1_r <= duffe_pkg::sat32(duffe_pkg::PROD_W'(acc_sum));
        default: ;
      endcase
      if (uw.pn_wr) begin
        pn_r <= pn_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Oscillator state and sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      vel_r       <= '0;
      phase_acc_r <= '0;
      busy_r      <= 1'b0;
      upc_r       <= duffe_pkg::UPC_S0;
    end else begin
      if (fin_step_fire) begin
        pos_r       <= pn_r;
        vel_r       <= vn_nxt;
        phase_acc_r <= phase_arg;
      end else if (fin_load_fire) begin
        pos_r       <= in_r.load_position;
        vel_r       <= in_r.load_velocity;
        phase_acc_r <= phase_step_r;
      end
      if (adv) begin
        case (uw.jmp)
          duffe_pkg::J_LOAD: begin
            upc_r <= (in_r.mode == duffe_pkg::MODE_LOAD) ? uw.target : upc_r + 1'b1;
          end
          duffe_pkg::J_END: begin
            // Retire the item; a transfer on this edge restarts the program.
            busy_r <= in_fire;
            upc_r  <= duffe_pkg::UPC_S0;
          end
          default: begin
            upc_r <= upc_r + 1'b1;
          end
        endcase
      end else if (in_fire) begin
        busy_r <= 1'b1;
        upc_r  <= duffe_pkg::UPC_S0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: one transfer per finished item.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (fin_step_fire || fin_load_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (fin_step_fire) begin
      out_data_r.position <= pn_r;
      out_data_r.velocity <= vn_nxt;
    end else if (fin_load_fire) begin
      out_data_r.position <= in_r.load_position;
      out_data_r.velocity <= in_r.load_velocity;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DUFFE_ASSERT(a_accept_starts_program,
    (in_valid && !in_stall) |=> (busy_r && upc_r == duffe_pkg::UPC_S0),
    "accepted item did not start the program")
  `DUFFE_ASSERT(a_load_result,
    fin_load_fire |=> (out_valid_r && out_data_r.position == $past(in_r.load_position)),
    "load result does not match loaded position")
  `DUFFE_ASSERT(a_phase_advance,
    fin_step_fire |=> (phase_acc_r == $past(phase_acc_r + phase_step_r)),
    "phase did not advance by one step")
  `DUFFE_ASSERT_RST(a_reset_idle, !rst_n |=> !busy_r, "sequencer busy after reset")

endmodule
